FILE: rtl/mfcm_pkg.sv
// ----------------------------------------------------------------------------
// mfcm_pkg: shared types and constants of the motion fingerprint matcher
// Item and result structs, controller codes and the command/status bundles.
// ----------------------------------------------------------------------------
package mfcm_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int TAB_AW        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int MAX_ELEM      = 128;
  localparam int ELEM_W        = $clog2(MAX_ELEM + 1);
  localparam int FP_W          = 59;
  localparam int MUL_AW        = 52;
  localparam int MUL_BW        = 40;
  localparam int MUL_PW        = MUL_AW + MUL_BW;
  localparam int SRCH_W        = MUL_PW + 1;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIFF    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SPEED  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DISP   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTOUR_RNG = 8'd3;

  // (63e6)^2: scales speed in mm per microsecond to the 63-step bucket range.
  localparam logic [MUL_AW-1:0] SPEED_SCALE = 52'd3969000000000000;
  localparam logic [11:0]       BUCKET_SQ   = 12'd3969;
  localparam logic [5:0]        BUCKET_MAX  = 6'd63;
  localparam logic [4:0]        CONF_NEW    = 5'd12;
  localparam logic [4:0]        CONF_MAX    = 5'd20;

  typedef struct packed {
    logic signed [15:0] contour_delta;
    logic signed [15:0] disp_x;
    logic signed [15:0] disp_y;
    logic signed [15:0] disp_z;
    logic [23:0]        duration_us;
    logic               last_element;
  } in_item_t;

  typedef struct packed {
    logic [6:0]      concept_index;
    logic            is_new;
    logic            table_full;
    logic [15:0]     occurrences;
    logic [4:0]      confidence;
    logic [6:0]      best_distance;
    logic [FP_W-1:0] fingerprint;
  } out_item_t;

  typedef struct packed {
    logic [FP_W-1:0] fp;
    logic [4:0]      conf;
    logic [15:0]     occ;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_SRCH, ST_SCAN_RD, ST_SCAN_EV, ST_COMMIT
  } state_t;

  typedef enum logic [3:0] {
    J_DX, J_DY, J_DZ, J_S, J_S2, J_KD, J_FD, J_CD, J_SPD, J_DSP, J_C0, J_C1, J_C2
  } job_t;

  typedef struct packed {
    logic elem_acc;
    logic mul_go;
    logic mul_step;
    logic srch_go;
    logic srch_step;
    logic save;
    logic scan_init;
    logic scan_rd;
    logic scan_ev;
    logic commit;
    job_t job;
  } ctl_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic srch_stop;
    logic scan_last;
    logic table_empty;
  } ctl_sts_t;

  function automatic logic is_mul_job(input job_t j);
    return j inside {J_DX, J_DY, J_DZ, J_S, J_S2, J_KD, J_FD, J_CD};
  endfunction

endpackage

FILE: rtl/motion_fingerprint_concept_matcher.sv
// ----------------------------------------------------------------------------
// motion_fingerprint_concept_matcher: motion fingerprint and concept matcher
//
//   channel  direction  transfer when          payload
//   in_      in         start & !busy          in_data   (in_item_t)
//   out_     out        out_valid (1 cycle)    out_data  (out_item_t)
//   cfg_     in         cfg_valid & cfg_ready  cfg_index, cfg_data
//
// For an item that does not close a motion, busy stays low.
// The closing item runs eight shift-add multiplies (one multiplier bit a
// cycle, each with set-up), five bucket searches and a table scan with a read
// and an evaluation step per used entry, then the table update; the result
// strobe follows in the cycle after the update.
// Reset is synchronous and active low and needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module motion_fingerprint_concept_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  mfcm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  output mfcm_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mfcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfcm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mfcm_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  mfcm_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .last_element (in_data.last_element),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy)
  );

  mfcm_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/mfcm_ctrl.sv
// ----------------------------------------------------------------------------
// mfcm_ctrl: sequencer of the motion fingerprint matcher
// Steps through the multiply and bucket-search jobs, the table scan and the
// final table update for the item that closes a motion.
// ----------------------------------------------------------------------------
module mfcm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               last_element,
  input  mfcm_pkg::ctl_sts_t sts,
  output mfcm_pkg::ctl_cmd_t cmd,
  output logic               busy
);
  import mfcm_pkg::*;

  state_t state_r, state_nxt;
  job_t   job_r, job_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= J_DX;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    case (state_r)
      ST_IDLE: begin
        if (start && last_element) begin
          state_nxt = ST_LOAD;
          job_nxt   = J_DX;
        end
      end
      ST_LOAD: state_nxt = is_mul_job(job_r) ? ST_MUL : ST_SRCH;
      ST_MUL: begin
        if (sts.mul_done) begin
          state_nxt = ST_LOAD;
          job_nxt   = job_t'(4'(job_r) + 4'd1);
        end
      end
      ST_SRCH: begin
        if (sts.srch_stop) begin
          if (job_r == J_C2) begin
            state_nxt = sts.table_empty ? ST_COMMIT : ST_SCAN_RD;
          end else begin
            state_nxt = ST_LOAD;
            job_nxt   = job_t'(4'(job_r) + 4'd1);
          end
        end
      end
      ST_SCAN_RD: state_nxt = ST_SCAN_EV;
      ST_SCAN_EV: state_nxt = sts.scan_last ? ST_COMMIT : ST_SCAN_RD;
      ST_COMMIT:  state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.job       = job_r;
    cmd.elem_acc  = (state_r == ST_IDLE) && start;
    cmd.mul_go    = (state_r == ST_LOAD) && is_mul_job(job_r);
    cmd.srch_go   = (state_r == ST_LOAD) && !is_mul_job(job_r);
    cmd.mul_step  = (state_r == ST_MUL);
    cmd.srch_step = (state_r == ST_SRCH);
    cmd.save      = ((state_r == ST_MUL) && sts.mul_done)
                 || ((state_r == ST_SRCH) && sts.srch_stop);
    cmd.scan_init = (state_r == ST_SRCH) && sts.srch_stop && (job_r == J_C2);
    cmd.scan_rd   = (state_r == ST_SCAN_RD);
    cmd.scan_ev   = (state_r == ST_SCAN_EV);
    cmd.commit    = (state_r == ST_COMMIT);
  end

  assign busy = (state_r != ST_IDLE);

endmodule

FILE: rtl/mfcm_dpath.sv
// ----------------------------------------------------------------------------
// mfcm_dpath: datapath of the motion fingerprint matcher
// Top-three contour ranking, a shift-add multiplier, an incremental bucket
// search, the concept table memory and the result register.
// ----------------------------------------------------------------------------
module mfcm_dpath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mfcm_pkg::ctl_cmd_t                    cmd,
  output mfcm_pkg::ctl_sts_t                    sts,
  input  mfcm_pkg::in_item_t                    in_data,
  input  logic                                  cfg_valid,
  input  logic [mfcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mfcm_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic                                  out_valid,
  output mfcm_pkg::out_item_t                   out_data
);
  import mfcm_pkg::*;

  function automatic logic [2:0] direction_of(input logic signed [15:0] x,
                                              input logic signed [15:0] y);
    logic [16:0] ax, ay;
    logic [2:0]  d;
    ax = x[15] ? 17'(-$signed({x[15], x})) : 17'({1'b0, x});
    ay = y[15] ? 17'(-$signed({y[15], y})) : 17'({1'b0, y});
    if (y > 0) begin
      if (x > 0)       d = (ay < ax) ? 3'd4 : 3'd5;
      else if (x == 0) d = 3'd6;
      else             d = (ay > ax) ? 3'd6 : 3'd7;
    end else if (y == 0) begin
      d = (x >= 0) ? 3'd4 : 3'd0;
    end else begin
      if (x > 0)       d = (ay <= ax) ? 3'd3 : 3'd2;
      else if (x == 0) d = 3'd2;
      else             d = (ay >= ax) ? 3'd1 : 3'd0;
    end
    return d;
  endfunction

  function automatic logic [6:0] popcnt(input logic [FP_W-1:0] v);
    logic [6:0] s;
    s = '0;
    for (int i = 0; i < FP_W; i++) s = s + 7'(v[i]);
    return s;
  endfunction

  function automatic logic [15:0] abs16(input logic signed [15:0] v);
    return v[15] ? 16'(-v) : 16'(v);
  endfunction

  // Configuration
  logic [6:0]  max_diff_r;
  logic [15:0] full_speed_r, full_disp_r;
  logic [14:0] half_rng_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_diff_r   <= 7'd9;
      full_speed_r <= 16'd5000;
      full_disp_r  <= 16'd2000;
      half_rng_r   <= 15'd1000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_DIFF:    max_diff_r   <= cfg_data[6:0];
        REG_FULL_SPEED:  full_speed_r <= cfg_data;
        REG_FULL_DISP:   full_disp_r  <= cfg_data;
        REG_CONTOUR_RNG: half_rng_r   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic [15:0] fs_eff, fd_eff;
  logic [14:0] h_eff;
  assign fs_eff = (full_speed_r == '0) ? 16'd1 : full_speed_r;
  assign fd_eff = (full_disp_r == '0) ? 16'd1 : full_disp_r;
  assign h_eff  = (half_rng_r == '0) ? 15'd1 : half_rng_r;

  // Top-three ranking of contour changes
  logic [15:0]        top_mag_r [3];
  logic signed [15:0] top_val_r [3];
  logic [1:0]         top_cnt_r;
  logic [ELEM_W-1:0]  elem_cnt_r;
  logic [15:0]        new_mag;
  logic [1:0]         ins_pos;
  logic               p0, p1, p2;

  assign new_mag = abs16(in_data.contour_delta);
  assign p0 = (top_cnt_r > 2'd0) && (new_mag >= top_mag_r[0]);
  assign p1 = (top_cnt_r > 2'd1) && (new_mag >= top_mag_r[1]);
  assign p2 = (top_cnt_r > 2'd2) && (new_mag >= top_mag_r[2]);
  assign ins_pos = p0 ? 2'd0 : p1 ? 2'd1 : p2 ? 2'd2 : top_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_cnt_r  <= '0;
      elem_cnt_r <= '0;
    end else if (cmd.commit) begin
      top_cnt_r  <= '0;
      elem_cnt_r <= '0;
    end else if (cmd.elem_acc && (elem_cnt_r < ELEM_W'(MAX_ELEM))) begin
      elem_cnt_r <= elem_cnt_r + 1'b1;
      if (ins_pos != 2'd3) begin
        if (top_cnt_r != 2'd3) top_cnt_r <= top_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.elem_acc && (elem_cnt_r < ELEM_W'(MAX_ELEM)) && (ins_pos != 2'd3)) begin
      for (int j = 0; j < 3; j++) begin
        if (2'(j) == ins_pos) begin
          top_mag_r[j] <= new_mag;
          top_val_r[j] <= in_data.contour_delta;
        end else if (2'(j) > ins_pos) begin
          top_mag_r[j] <= top_mag_r[(j > 0) ? j-1 : 0];
          top_val_r[j] <= top_val_r[(j > 0) ? j-1 : 0];
        end
      end
    end
  end

  // Motion fields, taken from the closing item
  logic [15:0] ax_r, ay_r, az_r;
  logic [23:0] dur_r;
  logic [2:0]  dir_r;

  always_ff @(posedge clk) begin
    if (cmd.elem_acc && in_data.last_element) begin
      ax_r  <= abs16(in_data.disp_x);
      ay_r  <= abs16(in_data.disp_y);
      az_r  <= abs16(in_data.disp_z);
      dur_r <= (in_data.duration_us == '0) ? 24'd1 : in_data.duration_us;
      dir_r <= direction_of(in_data.disp_x, in_data.disp_y);
    end
  end

  // Shift-add multiplier, one multiplier bit a cycle
  logic [MUL_PW-1:0] acc_r, a_sh_r;
  logic [MUL_BW-1:0] b_sh_r;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [33:0]       d2_r;
  logic [39:0]       s_r;
  logic [79:0]       s2_r;
  logic [85:0]       kd_r;
  logic [31:0]       fd2_r;
  logic [45:0]       cd_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.job)
      J_DX: begin mul_a = MUL_AW'(ax_r);  mul_b = MUL_BW'(ax_r); end
      J_DY: begin mul_a = MUL_AW'(ay_r);  mul_b = MUL_BW'(ay_r); end
      J_DZ: begin mul_a = MUL_AW'(az_r);  mul_b = MUL_BW'(az_r); end
      J_S:  begin mul_a = MUL_AW'(dur_r); mul_b = MUL_BW'(fs_eff); end
      J_S2: begin mul_a = MUL_AW'(s_r);   mul_b = s_r; end
      J_KD: begin mul_a = SPEED_SCALE;    mul_b = MUL_BW'(d2_r); end
      J_FD: begin mul_a = MUL_AW'(fd_eff); mul_b = MUL_BW'(fd_eff); end
      J_CD: begin mul_a = MUL_AW'(BUCKET_SQ); mul_b = MUL_BW'(d2_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      a_sh_r <= MUL_PW'(mul_a);
      b_sh_r <= mul_b;
      // The three squared displacement terms accumulate into one sum.
      if (cmd.job != J_DY && cmd.job != J_DZ) acc_r <= '0;
    end else if (cmd.mul_step && (b_sh_r != '0)) begin
      if (b_sh_r[0]) acc_r <= acc_r + a_sh_r;
      a_sh_r <= a_sh_r << 1;
      b_sh_r <= b_sh_r >> 1;
    end
  end

  // Bucket search: largest n up to 63 with n*P <= Q, or n*n*P <= Q when the
  // step grows, the square being built by adding odd multiples of P.
  logic [SRCH_W-1:0] t_r, u_r, inc_r, q_r;
  logic [5:0]        n_r;
  logic [SRCH_W:0]   t_try;
  logic [SRCH_W-1:0] srch_p, srch_q;
  logic              srch_sq, srch_stop;
  logic signed [15:0] cval;
  logic [1:0]        cidx;
  logic signed [17:0] cv;

  always_comb begin
    case (cmd.job)
      J_C1:    cidx = 2'd1;
      J_C2:    cidx = 2'd2;
      default: cidx = 2'd0;
    endcase
    cval = top_val_r[cidx];
    cv   = 18'(cval) + 18'($signed({1'b0, h_eff}));
    srch_p  = '0;
    srch_q  = '0;
    srch_sq = 1'b0;
    case (cmd.job)
      J_SPD: begin srch_p = SRCH_W'(s2_r);  srch_q = SRCH_W'(kd_r); srch_sq = 1'b1; end
      J_DSP: begin srch_p = SRCH_W'(fd2_r); srch_q = SRCH_W'(cd_r); srch_sq = 1'b1; end
      J_C0, J_C1, J_C2: begin
        srch_p = SRCH_W'({h_eff, 1'b0});
        if ((cidx < top_cnt_r) && (cv > 0)) srch_q = SRCH_W'(({cv, 6'b0}) - cv);
      end
      default: ;
    endcase
  end

  assign t_try     = (SRCH_W + 1)'(t_r) + (SRCH_W + 1)'(u_r);
  assign srch_stop = (n_r == BUCKET_MAX) || (t_try > (SRCH_W + 1)'(q_r));

  always_ff @(posedge clk) begin
    if (cmd.srch_go) begin
      n_r   <= '0;
      t_r   <= '0;
      u_r   <= srch_p;
      inc_r <= srch_sq ? (srch_p << 1) : '0;
      q_r   <= srch_q;
    end else if (cmd.srch_step && !srch_stop) begin
      n_r <= n_r + 6'd1;
      t_r <= t_try[SRCH_W-1:0];
      u_r <= u_r + inc_r;
    end
  end

  logic [5:0] sb_r, db_r;
  logic [5:0] cb_r [3];

  always_ff @(posedge clk) begin
    if (cmd.save) begin
      case (cmd.job)
        J_DZ:  d2_r  <= acc_r[33:0];
        J_S:   s_r   <= acc_r[39:0];
        J_S2:  s2_r  <= acc_r[79:0];
        J_KD:  kd_r  <= acc_r[85:0];
        J_FD:  fd2_r <= acc_r[31:0];
        J_CD:  cd_r  <= acc_r[45:0];
        J_SPD: sb_r  <= n_r;
        J_DSP: db_r  <= n_r;
        J_C0:  cb_r[0] <= n_r;
        J_C1:  cb_r[1] <= n_r;
        J_C2:  cb_r[2] <= n_r;
        default: ;
      endcase
    end
  end

  logic [FP_W-1:0] fp;
  assign fp = {dir_r, sb_r, db_r, cb_r[0], cb_r[1], cb_r[2], 26'b0};

  // Concept table scan
  entry_t          mem [TABLE_ENTRIES];
  entry_t          rd_r, best_e_r, wr_data;
  logic            wr_en;
  logic [TAB_AW-1:0] wr_addr;
  logic [CNT_W-1:0] used_r, k_r;
  logic [TAB_AW-1:0] best_k_r;
  logic [6:0]      best_d_r, ham_d;
  logic            found_r, qual;

  assign ham_d = popcnt(fp ^ rd_r.fp);
  assign qual = (ham_d <= max_diff_r)
             && ((10'd5 * (10'd64 - 10'(ham_d))) > (10'd16 * 10'(rd_r.conf)))
             && (!found_r || (ham_d < best_d_r));

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      k_r     <= '0;
      found_r <= 1'b0;
    end else if (cmd.scan_ev) begin
      k_r <= k_r + 1'b1;
      if (qual) begin
        found_r  <= 1'b1;
        best_k_r <= k_r[TAB_AW-1:0];
        best_d_r <= ham_d;
        best_e_r <= rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.scan_rd) rd_r <= mem[k_r[TAB_AW-1:0]];
  end

  // Table update and result
  out_item_t res;
  logic      has_room;

  assign has_room = (used_r < CNT_W'(TABLE_ENTRIES));

  always_comb begin
    res             = '0;
    res.fingerprint = fp;
    wr_en           = 1'b0;
    wr_addr         = best_k_r;
    wr_data         = best_e_r;
    if (found_r) begin
      wr_en        = cmd.commit;
      wr_data.occ  = (best_e_r.occ != 16'hFFFF) ? best_e_r.occ + 16'd1 : best_e_r.occ;
      wr_data.conf = (best_e_r.conf < CONF_MAX) ? best_e_r.conf + 5'd1 : best_e_r.conf;
      res.concept_index = 7'(best_k_r) + 7'd1;
      res.occurrences   = wr_data.occ;
      res.confidence    = wr_data.conf;
      res.best_distance = best_d_r;
    end else if (has_room) begin
      wr_en        = cmd.commit;
      wr_addr      = used_r[TAB_AW-1:0];
      wr_data.fp   = fp;
      wr_data.occ  = 16'd1;
      wr_data.conf = CONF_NEW;
      res.concept_index = 7'(used_r) + 7'd1;
      res.is_new        = 1'b1;
      res.occurrences   = 16'd1;
      res.confidence    = CONF_NEW;
    end else begin
      res.table_full = 1'b1;
    end
  end

  logic      out_valid_r;
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cmd.commit && !found_r && has_room) used_r <= used_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.mul_done    = (b_sh_r == '0);
  assign sts.srch_stop   = srch_stop;
  assign sts.scan_last   = (CNT_W'(k_r + 1'b1) == used_r);
  assign sts.table_empty = (used_r == '0);

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_ENTRIES))
    else $error("concept table fill count beyond table size");

  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("table update gave no result");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");

  a_grow_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(used_r))
    else $error("fill count changed outside a table update");

endmodule
